[hdl/bwbr_pkg.sv]
// Shared widths, register codes, reset values and the configuration bundle.
package bwbr_pkg;

    localparam int COORD_W = 12;
    localparam int SIZE_W  = 13;
    localparam int RAD_W   = 12;
    localparam int ORD_W   = 4;
    localparam int GAIN_W  = 17;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int S_W     = SQ_W + 1;
    localparam int NUM_W   = S_W + SQ_W;
    localparam int DEN_W   = 2 * S_W;
    localparam int Q_W     = 32;
    localparam int FRAC_W  = 16;
    localparam int POW_N   = 15;

    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_W;

    localparam logic [2:0] REG_ROWS   = 3'd0;
    localparam logic [2:0] REG_COLS   = 3'd1;
    localparam logic [2:0] REG_RADIUS = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_ORDER  = 3'd4;

    localparam logic [SIZE_W-1:0] RST_ROWS   = 13'd512;
    localparam logic [SIZE_W-1:0] RST_COLS   = 13'd512;
    localparam logic [RAD_W-1:0]  RST_RADIUS = 12'd150;
    localparam logic [RAD_W-1:0]  RST_WIDTH  = 12'd300;
    localparam logic [ORD_W-1:0]  RST_ORDER  = 4'd4;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_rows;
        logic [SIZE_W-1:0] frame_cols;
        logic [SQ_W-1:0]   d0_sq;
        logic [SQ_W-1:0]   w_sq;
        logic [ORD_W-1:0]  order;
    } t_cfg;

endpackage

[hdl/bwbr_if.sv]
// Stream interfaces for the coordinate beats and the gain beats.
interface bwbr_in_if import bwbr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] row_index;
    logic [COORD_W-1:0] col_index;
    modport source (output valid, row_index, col_index, input ready);
    modport sink   (input valid, row_index, col_index, output ready);
endinterface

interface bwbr_out_if import bwbr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] gain;
    logic              ratio_saturated;
    modport source (output valid, gain, ratio_saturated, input ready);
    modport sink   (input valid, gain, ratio_saturated, output ready);
endinterface

[hdl/butterworth_band_reject_gain.sv]
// Top level of the Butterworth band-reject gain pipeline with its APB register file.
//
// Each coordinate beat (row_index, col_index) yields one gain beat, H = 1/(1+p) in
// unsigned Q1.16 where 65536 is 1.0, with ratio_saturated set whenever the squared
// ratio or its power overflowed, in which case the gain is 0. One beat is taken every
// cycle while the output is not stalled. The stages are 4 front stages for the distance,
// the two products, 33 stages of the one-bit-per-stage ratio divider, 15 multiply
// stages of the power chain (one per possible order) and 18 stages of the gain divider.
// The whole pipeline advances together and holds when a result beat is offered and not
// taken, so beats are never lost or repeated. Registers sit at byte addresses 0x00
// (frame_rows), 0x04 (frame_cols), 0x08 (notch_radius), 0x0C (band_width) and 0x10
// (filter_order); write them only while no beat is in flight. The squares of the
// radius and width are registered from them in the cycle after a write.
module butterworth_band_reject_gain import bwbr_pkg::*; #(
    parameter int MAX_SIZE = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bwbr_in_if.sink     i_in,
    bwbr_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Register file.
    logic [SIZE_W-1:0] r_rows, r_cols;
    logic [RAD_W-1:0]  r_radius, r_width;
    logic [ORD_W-1:0]  r_order;
    logic [SQ_W-1:0]   r_d0_sq, r_w_sq;
    logic              wr;
    logic [2:0]        reg_idx;
    t_cfg              cfg;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= RST_ROWS;
            r_cols   <= RST_COLS;
            r_radius <= RST_RADIUS;
            r_width  <= RST_WIDTH;
            r_order  <= RST_ORDER;
        end else if (wr) begin
            unique case (reg_idx)
                REG_ROWS:   r_rows   <= pwdata[SIZE_W-1:0];
                REG_COLS:   r_cols   <= pwdata[SIZE_W-1:0];
                REG_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                REG_WIDTH:  r_width  <= pwdata[RAD_W-1:0];
                REG_ORDER:  r_order  <= pwdata[ORD_W-1:0];
                default: ;
            endcase
        end
    end

    // The squares are kept in registers so that no multiplier feeds another directly.
    always_ff @(posedge i_clk) begin
        r_d0_sq <= SQ_W'(r_radius) * SQ_W'(r_radius);
        r_w_sq  <= SQ_W'(r_width) * SQ_W'(r_width);
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROWS:   prdata = 32'(r_rows);
            REG_COLS:   prdata = 32'(r_cols);
            REG_RADIUS: prdata = 32'(r_radius);
            REG_WIDTH:  prdata = 32'(r_width);
            REG_ORDER:  prdata = 32'(r_order);
            default:    prdata = '0;
        endcase
    end

    assign cfg.frame_rows = r_rows;
    assign cfg.frame_cols = r_cols;
    assign cfg.d0_sq      = r_d0_sq;
    assign cfg.w_sq       = r_w_sq;
    assign cfg.order      = r_order;

    // The pipeline moves whenever the result slot is empty or being taken.
    logic             en;
    logic             f_vld, f_zero;
    logic [NUM_W-1:0] f_num;
    logic [DEN_W-1:0] f_den;
    logic             d_vld, d_sat;
    logic [Q_W-1:0]   d_q;
    logic             p_vld, p_sat;
    logic [Q_W-1:0]   p_p;

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    bwbr_front #(.MAX_SIZE(MAX_SIZE)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in.valid),
        .i_row   (i_in.row_index),
        .i_col   (i_in.col_index),
        .i_cfg   (cfg),
        .o_vld   (f_vld),
        .o_zero  (f_zero),
        .o_num   (f_num),
        .o_den   (f_den)
    );

    bwbr_qdiv u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_zero  (f_zero),
        .i_num   (f_num),
        .i_den   (f_den),
        .o_vld   (d_vld),
        .o_sat   (d_sat),
        .o_q     (d_q)
    );

    bwbr_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_order (r_order),
        .i_vld   (d_vld),
        .i_sat   (d_sat),
        .i_q     (d_q),
        .o_vld   (p_vld),
        .o_sat   (p_sat),
        .o_p     (p_p)
    );

    bwbr_gdiv u_gdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (p_vld),
        .i_sat   (p_sat),
        .i_p     (p_p),
        .o_vld   (o_out.valid),
        .o_sat   (o_out.ratio_saturated),
        .o_gain  (o_out.gain)
    );

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result beat offered right after reset");

    a_sat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ratio_saturated |-> o_out.gain == '0)
        else $error("saturated beat carries a nonzero gain");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.gain <= GAIN_W'(ONE_Q))
        else $error("gain above 1.0");

    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(f_num) && $stable(d_q) && $stable(p_p))
        else $error("pipeline moved during a stall");

endmodule

[hdl/bwbr_front.sv]
// Front stages: centre offsets, squared distance, ring offset, numerator and denominator.
module bwbr_front import bwbr_pkg::*; #(
    parameter int MAX_SIZE = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_col,
    input  t_cfg               i_cfg,
    output logic               o_vld,
    output logic               o_zero,
    output logic [NUM_W-1:0]   o_num,
    output logic [DEN_W-1:0]   o_den
);

    localparam logic [16:0] MAX17 = 17'(MAX_SIZE);

    function automatic logic [COORD_W-1:0] centre(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] sz;
        sz = ({4'b0, size} > MAX17) ? MAX17[SIZE_W-1:0] : size;
        return sz[SIZE_W-1:1];
    endfunction

    logic [COORD_W-1:0] cr, cc;
    logic [3:0]         r_vld;
    logic [COORD_W-1:0] r_ar, r_ac;
    logic [SQ_W-1:0]    r_sr, r_sc;
    logic [S_W-1:0]     r_s, r_diff;
    logic [S_W-1:0]     s_sum;

    assign cr    = centre(i_cfg.frame_rows);
    assign cc    = centre(i_cfg.frame_cols);
    assign s_sum = S_W'(r_sr) + S_W'(r_sc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ar   <= (i_row >= cr) ? i_row - cr : cr - i_row;
            r_ac   <= (i_col >= cc) ? i_col - cc : cc - i_col;
            r_sr   <= SQ_W'(r_ar) * SQ_W'(r_ar);
            r_sc   <= SQ_W'(r_ac) * SQ_W'(r_ac);
            r_s    <= s_sum;
            r_diff <= (s_sum >= S_W'(i_cfg.d0_sq)) ? s_sum - S_W'(i_cfg.d0_sq)
                                                   : S_W'(i_cfg.d0_sq) - s_sum;
            o_num  <= NUM_W'(r_s) * NUM_W'(i_cfg.w_sq);
            o_den  <= DEN_W'(r_diff) * DEN_W'(r_diff);
            o_zero <= (r_diff == '0);
        end
    end

    assign o_vld = r_vld[3];

endmodule

[hdl/bwbr_qdiv.sv]
// Pipelined restoring divider for the Q16.16 squared ratio, one quotient bit per stage.
module bwbr_qdiv import bwbr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic             i_zero,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_vld,
    output logic             o_sat,
    output logic [Q_W-1:0]   o_q
);

    localparam int REM_W = NUM_W + FRAC_W;
    localparam int TRY_W = DEN_W + Q_W;

    logic [Q_W:0]       r_vld;
    logic [Q_W:0]       r_sat;
    logic [REM_W-1:0]   r_rem [0:Q_W];
    logic [DEN_W-1:0]   r_den [0:Q_W];
    logic [Q_W-1:0]     r_q   [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    // Integer part of 65536 or more means num >= den * 2^16.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= i_zero ||
                ({(DEN_W + FRAC_W - NUM_W)'(0), i_num} >= {i_den, FRAC_W'(0)});
            r_rem[0] <= {i_num, FRAC_W'(0)};
            r_den[0] <= i_den;
            r_q[0]   <= '0;
        end
    end

    for (genvar j = 1; j <= Q_W; j++) begin : g_stage
        localparam int K = Q_W - j;
        logic [TRY_W-1:0] trial;
        logic [TRY_W-1:0] sub;
        logic             ge;

        assign trial = {Q_W'(0), r_den[j-1]} << K;
        assign ge    = {(TRY_W - REM_W)'(0), r_rem[j-1]} >= trial;
        assign sub   = {(TRY_W - REM_W)'(0), r_rem[j-1]} - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[j] <= r_sat[j-1];
                r_den[j] <= r_den[j-1];
                r_rem[j] <= ge ? sub[REM_W-1:0] : r_rem[j-1];
                r_q[j]   <= {r_q[j-1][Q_W-2:0], ge};
            end
        end
    end

    assign o_vld = r_vld[Q_W];
    assign o_sat = r_sat[Q_W];
    assign o_q   = r_q[Q_W];

endmodule

[hdl/bwbr_pow.sv]
// Power chain: one 32x32 multiply per stage, raising the squared ratio to the order.
module bwbr_pow import bwbr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [ORD_W-1:0] i_order,
    input  logic             i_vld,
    input  logic             i_sat,
    input  logic [Q_W-1:0]   i_q,
    output logic             o_vld,
    output logic             o_sat,
    output logic [Q_W-1:0]   o_p
);

    logic [POW_N:1]   r_vld;
    logic [POW_N:1]   r_sat;
    logic [Q_W-1:0]   r_p [1:POW_N];
    logic [Q_W-1:0]   r_q [1:POW_N];

    for (genvar j = 1; j <= POW_N; j++) begin : g_stage
        logic             vld_in, sat_in, active;
        logic [Q_W-1:0]   p_in, q_in;
        logic [2*Q_W-1:0] prod;

        if (j == 1) begin : g_first
            assign vld_in = i_vld;
            assign sat_in = i_sat;
            assign p_in   = ONE_Q;
            assign q_in   = i_q;
        end else begin : g_next
            assign vld_in = r_vld[j-1];
            assign sat_in = r_sat[j-1];
            assign p_in   = r_p[j-1];
            assign q_in   = r_q[j-1];
        end

        assign active = (ORD_W'(j - 1) < i_order) && !sat_in;
        assign prod   = (2*Q_W)'(p_in) * (2*Q_W)'(q_in);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        // Bits above 2^32 after the Q16 shift mean the power has saturated.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j]   <= q_in;
                r_sat[j] <= sat_in || (active && (prod[2*Q_W-1:Q_W+FRAC_W] != '0));
                r_p[j]   <= active ? prod[Q_W+FRAC_W-1:FRAC_W] : p_in;
            end
        end
    end

    assign o_vld = r_vld[POW_N];
    assign o_sat = r_sat[POW_N];
    assign o_p   = r_p[POW_N];

endmodule

[hdl/bwbr_gdiv.sv]
// Pipelined restoring divider forming the rounded gain 1/(1+p) in Q1.16.
module bwbr_gdiv import bwbr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic              i_sat,
    input  logic [Q_W-1:0]    i_p,
    output logic              o_vld,
    output logic              o_sat,
    output logic [GAIN_W-1:0] o_gain
);

    localparam int DV_W  = Q_W + 1;
    localparam int REM_W = Q_W + 2;
    localparam int TRY_W = DV_W + GAIN_W;

    logic [DV_W-1:0]  den_in;
    logic [REM_W-1:0] dvd_in;

    logic [GAIN_W:0]    r_vld;
    logic [GAIN_W:0]    r_sat;
    logic [REM_W-1:0]   r_rem [0:GAIN_W];
    logic [DV_W-1:0]    r_den [0:GAIN_W];
    logic [GAIN_W-1:0]  r_q   [0:GAIN_W];

    assign den_in = DV_W'(i_p) + DV_W'(ONE_Q);
    assign dvd_in = (REM_W'(1) << Q_W) + REM_W'(den_in >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= i_sat;
            r_rem[0] <= dvd_in;
            r_den[0] <= den_in;
            r_q[0]   <= '0;
        end
    end

    for (genvar j = 1; j <= GAIN_W; j++) begin : g_stage
        localparam int K = GAIN_W - j;
        logic [TRY_W-1:0] trial;
        logic [TRY_W-1:0] sub;
        logic             ge;

        assign trial = {GAIN_W'(0), r_den[j-1]} << K;
        assign ge    = {(TRY_W - REM_W)'(0), r_rem[j-1]} >= trial;
        assign sub   = {(TRY_W - REM_W)'(0), r_rem[j-1]} - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[j] <= r_sat[j-1];
                r_den[j] <= r_den[j-1];
                r_rem[j] <= ge ? sub[REM_W-1:0] : r_rem[j-1];
                r_q[j]   <= {r_q[j-1][GAIN_W-2:0], ge};
            end
        end
    end

    assign o_vld  = r_vld[GAIN_W];
    assign o_sat  = r_sat[GAIN_W];
    assign o_gain = r_sat[GAIN_W] ? '0 : r_q[GAIN_W];

endmodule
